/* hdl/swmc_pkg.sv */
package swmc_pkg;

   localparam int FINEST_MICROSTEPS    = 64;
   localparam int TICKS_PER_SPEED_UNIT = 1;
   localparam int QUIET_EXTRA_TICKS    = 64;
   localparam int BACKOFF_STEPS        = 2000;
   localparam int POSITION_BITS        = 32;

   localparam int POS_W     = POSITION_BITS;
   localparam int HALF_W    = $clog2(255 * TICKS_PER_SPEED_UNIT + QUIET_EXTRA_TICKS + 1);
   localparam int STEP_W    = $clog2(FINEST_MICROSTEPS / 8 + 1);
   localparam int BACKOFF_W = $clog2(BACKOFF_STEPS + 1);
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;

   localparam logic [1:0] RES_FINEST  = 2'd3;
   localparam logic [7:0] SEEK_SPEED  = 8'd2;
   localparam logic [7:0] BACK_SPEED  = 8'd1;
   localparam logic [7:0] SLOW_SPEED  = 8'd4;

   typedef enum logic [2:0] {
      OP_NONE    = 3'd0,
      OP_OPEN    = 3'd1,
      OP_CLOSE   = 3'd2,
      OP_HOME    = 3'd3,
      OP_STOP    = 3'd4,
      OP_SET_RES = 3'd5,
      OP_ENABLE  = 3'd6,
      OP_DISABLE = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      MD_IDLE    = 3'd0,
      MD_OPEN    = 3'd1,
      MD_CLOSE   = 3'd2,
      MD_SEEK    = 3'd3,
      MD_RELEASE = 3'd4,
      MD_BACKOFF = 3'd5,
      MD_SLOW    = 3'd6,
      MD_ALIGN   = 3'd7
   } mode_type;

   typedef enum logic [2:0] {
      REG_SPEED           = 3'd0,
      REG_EXTRA_DELAY     = 3'd1,
      REG_HOME_DIRECTION  = 3'd2,
      REG_OPEN_DIRECTION  = 3'd3,
      REG_CLOSE_DIRECTION = 3'd4,
      REG_OPEN_TARGET     = 3'd5,
      REG_CLOSED_TARGET   = 3'd6
   } reg_type;

   typedef struct packed {
      logic              stop;
      logic              drv_on;
      logic              drv_off;
      logic              open;
      logic              close;
      logic              home;
      logic              set_res;
      logic              limit_home;
      logic              limit_open;
      logic              limit_closed;
      logic [1:0]        res_code;
   } cmd_type;

   typedef struct packed {
      logic [7:0]        speed;
      logic              extra_delay;
      logic              home_direction;
      logic              open_direction;
      logic              close_direction;
      logic signed [31:0] open_target;
      logic signed [31:0] closed_target;
   } csr_type;

   function automatic logic [HALF_W-1:0] half_for(input logic [7:0] spd, input logic quiet);
      int h;
      h = int'(spd) * TICKS_PER_SPEED_UNIT + (quiet ? QUIET_EXTRA_TICKS : 0);
      if (h == 0) begin
         h = 1;
      end
      return HALF_W'(h);
   endfunction

   function automatic logic [STEP_W-1:0] step_size(input logic [1:0] code);
      int s;
      s = FINEST_MICROSTEPS >> (3 + int'(code));
      if (s == 0) begin
         s = 1;
      end
      return STEP_W'(s);
   endfunction

   function automatic logic [POS_W-1:0] to_pos(input logic signed [31:0] t);
      return POS_W'(t);
   endfunction

endpackage

/* hdl/swmc_csr.sv */
module swmc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [swmc_pkg::ADDR_W-1:0]   paddr,
   input  logic [swmc_pkg::DATA_W-1:0]   pwdata,
   output logic [swmc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output swmc_pkg::csr_type             csr
);

   swmc_pkg::csr_type csr_ff;
   swmc_pkg::csr_type csr_in;
   swmc_pkg::reg_type reg_sel;
   logic              wr_en;

   assign reg_sel = swmc_pkg::reg_type'(paddr[4:2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign csr     = csr_ff;

   always_comb begin
      csr_in = csr_ff;
      if (wr_en) begin
         unique case (reg_sel)
            swmc_pkg::REG_SPEED:           csr_in.speed           = pwdata[7:0];
            swmc_pkg::REG_EXTRA_DELAY:     csr_in.extra_delay     = pwdata[0];
            swmc_pkg::REG_HOME_DIRECTION:  csr_in.home_direction  = pwdata[0];
            swmc_pkg::REG_OPEN_DIRECTION:  csr_in.open_direction  = pwdata[0];
            swmc_pkg::REG_CLOSE_DIRECTION: csr_in.close_direction = pwdata[0];
            swmc_pkg::REG_OPEN_TARGET:     csr_in.open_target     = signed'(pwdata);
            swmc_pkg::REG_CLOSED_TARGET:   csr_in.closed_target   = signed'(pwdata);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         swmc_pkg::REG_SPEED:           prdata = {24'd0, csr_ff.speed};
         swmc_pkg::REG_EXTRA_DELAY:     prdata = {31'd0, csr_ff.extra_delay};
         swmc_pkg::REG_HOME_DIRECTION:  prdata = {31'd0, csr_ff.home_direction};
         swmc_pkg::REG_OPEN_DIRECTION:  prdata = {31'd0, csr_ff.open_direction};
         swmc_pkg::REG_CLOSE_DIRECTION: prdata = {31'd0, csr_ff.close_direction};
         swmc_pkg::REG_OPEN_TARGET:     prdata = csr_ff.open_target;
         swmc_pkg::REG_CLOSED_TARGET:   prdata = csr_ff.closed_target;
         default:                       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.speed           <= 8'd1;
         csr_ff.extra_delay     <= 1'b0;
         csr_ff.home_direction  <= 1'b0;
         csr_ff.open_direction  <= 1'b0;
         csr_ff.close_direction <= 1'b1;
         csr_ff.open_target     <= '0;
         csr_ff.closed_target   <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

endmodule

/* hdl/swmc_front.sv */
module swmc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_operation,
   input  logic              req_limit_home,
   input  logic              req_limit_open,
   input  logic              req_limit_closed,
   input  logic [1:0]        req_resolution_code,
   output logic              deq_valid,
   input  logic              deq_ready,
   output swmc_pkg::cmd_type deq_cmd
);

   swmc_pkg::cmd_type mem_ff [2];
   swmc_pkg::cmd_type cmd;
   swmc_pkg::op_type  op;
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;

   assign op = swmc_pkg::op_type'(req_operation);

   always_comb begin
      cmd              = '0;
      cmd.limit_home   = req_limit_home;
      cmd.limit_open   = req_limit_open;
      cmd.limit_closed = req_limit_closed;
      cmd.res_code     = req_resolution_code;
      unique case (op)
         swmc_pkg::OP_NONE:    begin end
         swmc_pkg::OP_OPEN:    cmd.open    = 1'b1;
         swmc_pkg::OP_CLOSE:   cmd.close   = 1'b1;
         swmc_pkg::OP_HOME:    cmd.home    = 1'b1;
         swmc_pkg::OP_STOP:    cmd.stop    = 1'b1;
         swmc_pkg::OP_SET_RES: cmd.set_res = 1'b1;
         swmc_pkg::OP_ENABLE:  cmd.drv_on  = 1'b1;
         swmc_pkg::OP_DISABLE: cmd.drv_off = 1'b1;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid & ~req_stall;
   assign deq_valid = (count_ff != 2'd0);
   assign pop       = deq_valid & deq_ready;
   assign deq_cmd   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

/* hdl/swmc_back.sv */
module swmc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  swmc_pkg::csr_type        csr,
   input  logic                     deq_valid,
   output logic                     deq_ready,
   input  swmc_pkg::cmd_type        deq_cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_step_pulse,
   output logic                     rsp_dir_level,
   output logic [1:0]               rsp_microstep_pins,
   output logic                     rsp_enable_n,
   output logic signed [31:0]       rsp_position,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output logic                     rsp_success
);

   logic [swmc_pkg::POS_W-1:0]     pos_ff, pos_in;
   logic [1:0]                     res_ff, res_in;
   logic                           dir_ff, dir_in;
   logic                           pulse_ff, pulse_in;
   logic [swmc_pkg::HALF_W-1:0]    timer_ff, timer_in;
   logic [swmc_pkg::HALF_W-1:0]    half_ff, half_in;
   swmc_pkg::mode_type             mode_ff, mode_in;
   logic [swmc_pkg::BACKOFF_W-1:0] backoff_ff, backoff_in;
   logic                           stop_ff, stop_in;
   logic                           enable_ff, enable_in;
   logic                           sdir_ff, sdir_in;
   logic [1:0]                     sres_ff, sres_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           step_out_ff;
   logic                           dir_out_ff;
   logic [1:0]                     res_out_ff;
   logic                           enable_out_ff;
   logic signed [31:0]             pos_out_ff;
   logic                           busy_out_ff;
   logic                           done_out_ff;
   logic                           succ_out_ff;

   logic                           take;
   logic                           done;
   logic                           succ;
   logic                           step_out;
   logic                           start;
   logic [swmc_pkg::HALF_W-1:0]    start_half;
   logic                           pulse_mid;
   logic [swmc_pkg::HALF_W-1:0]    timer_mid;
   logic [swmc_pkg::HALF_W-1:0]    timer_dec;
   logic                           limit_hit;
   logic [swmc_pkg::POS_W-1:0]     target;
   logic [swmc_pkg::STEP_W-1:0]    low_bits;
   logic [swmc_pkg::STEP_W-1:0]    mag;
   logic                           pos_neg;

   assign take      = deq_valid & (~rsp_valid_ff | ~rsp_stall);
   assign deq_ready = take;
   assign pos_neg   = pos_ff[swmc_pkg::POS_W-1];
   assign low_bits  = pos_ff[swmc_pkg::STEP_W-1:0];

   always_comb begin
      pos_in     = pos_ff;
      res_in     = res_ff;
      dir_in     = dir_ff;
      pulse_in   = pulse_ff;
      timer_in   = timer_ff;
      half_in    = half_ff;
      mode_in    = mode_ff;
      backoff_in = backoff_ff;
      stop_in    = stop_ff;
      enable_in  = enable_ff;
      sdir_in    = sdir_ff;
      sres_in    = sres_ff;
      done       = 1'b0;
      succ       = 1'b0;
      step_out   = 1'b0;
      start      = 1'b0;
      start_half = '0;
      limit_hit  = 1'b0;
      target     = '0;
      mag        = '0;

      priority if (deq_cmd.stop) begin
         stop_in = 1'b1;
      end else if (deq_cmd.drv_on) begin
         enable_in = 1'b0;
      end else if (deq_cmd.drv_off) begin
         enable_in = 1'b1;
      end else if (mode_ff == swmc_pkg::MD_IDLE) begin
         priority if (deq_cmd.open) begin
            dir_in  = csr.open_direction;
            stop_in = 1'b0;
            mode_in = swmc_pkg::MD_OPEN;
         end else if (deq_cmd.close) begin
            dir_in  = csr.close_direction;
            stop_in = 1'b0;
            mode_in = swmc_pkg::MD_CLOSE;
         end else if (deq_cmd.home) begin
            sdir_in = dir_ff;
            sres_in = res_ff;
            dir_in  = csr.home_direction;
            res_in  = swmc_pkg::RES_FINEST;
            mode_in = swmc_pkg::MD_SEEK;
         end else if (deq_cmd.set_res) begin
            if (deq_cmd.res_code < res_ff) begin
               sdir_in = dir_ff;
               sres_in = deq_cmd.res_code;
               mode_in = swmc_pkg::MD_ALIGN;
            end else begin
               res_in = deq_cmd.res_code;
               done   = 1'b1;
               succ   = 1'b1;
            end
         end else begin
         end
      end else begin
      end

      if (mode_in != swmc_pkg::MD_IDLE && !pulse_ff && timer_ff == '0) begin
         unique case (mode_in)
            swmc_pkg::MD_OPEN, swmc_pkg::MD_CLOSE: begin
               limit_hit = (mode_in == swmc_pkg::MD_OPEN) ? deq_cmd.limit_open
                                                          : deq_cmd.limit_closed;
               target    = (mode_in == swmc_pkg::MD_OPEN) ? swmc_pkg::to_pos(csr.open_target)
                                                          : swmc_pkg::to_pos(csr.closed_target);
               priority if (stop_in) begin
                  mode_in = swmc_pkg::MD_IDLE;
                  done    = 1'b1;
                  succ    = 1'b0;
               end else if (limit_hit || pos_ff == target) begin
                  mode_in = swmc_pkg::MD_IDLE;
                  done    = 1'b1;
                  succ    = 1'b1;
               end else begin
                  start      = 1'b1;
                  start_half = swmc_pkg::half_for(csr.speed, csr.extra_delay);
               end
            end
            swmc_pkg::MD_SEEK: begin
               start = 1'b1;
               if (deq_cmd.limit_home) begin
                  mode_in    = swmc_pkg::MD_RELEASE;
                  dir_in     = ~csr.home_direction;
                  start_half = swmc_pkg::half_for(swmc_pkg::BACK_SPEED, csr.extra_delay);
               end else begin
                  start_half = swmc_pkg::half_for(swmc_pkg::SEEK_SPEED, csr.extra_delay);
               end
            end
            swmc_pkg::MD_RELEASE: begin
               start      = 1'b1;
               start_half = swmc_pkg::half_for(swmc_pkg::BACK_SPEED, csr.extra_delay);
               if (!deq_cmd.limit_home) begin
                  mode_in    = swmc_pkg::MD_BACKOFF;
                  backoff_in = swmc_pkg::BACKOFF_W'(swmc_pkg::BACKOFF_STEPS - 1);
               end
            end
            swmc_pkg::MD_BACKOFF: begin
               if (backoff_ff == '0) begin
                  mode_in = swmc_pkg::MD_SLOW;
                  dir_in  = csr.home_direction;
                  if (deq_cmd.limit_home) begin
                     pos_in  = '0;
                     dir_in  = sdir_in;
                     res_in  = sres_in;
                     mode_in = swmc_pkg::MD_IDLE;
                     done    = 1'b1;
                     succ    = 1'b1;
                  end else begin
                     start      = 1'b1;
                     start_half = swmc_pkg::half_for(swmc_pkg::SLOW_SPEED, csr.extra_delay);
                  end
               end else begin
                  backoff_in = backoff_ff - swmc_pkg::BACKOFF_W'(1);
                  start      = 1'b1;
                  start_half = swmc_pkg::half_for(swmc_pkg::BACK_SPEED, csr.extra_delay);
               end
            end
            swmc_pkg::MD_SLOW: begin
               if (deq_cmd.limit_home) begin
                  pos_in  = '0;
                  dir_in  = sdir_in;
                  res_in  = sres_in;
                  mode_in = swmc_pkg::MD_IDLE;
                  done    = 1'b1;
                  succ    = 1'b1;
               end else begin
                  start      = 1'b1;
                  start_half = swmc_pkg::half_for(swmc_pkg::SLOW_SPEED, csr.extra_delay);
               end
            end
            swmc_pkg::MD_ALIGN: begin
               mag = (pos_neg ? (~low_bits + swmc_pkg::STEP_W'(1)) : low_bits)
                     & (swmc_pkg::step_size(sres_in) - swmc_pkg::STEP_W'(1));
               if (mag < swmc_pkg::step_size(res_in)) begin
                  dir_in  = sdir_in;
                  res_in  = sres_in;
                  mode_in = swmc_pkg::MD_IDLE;
                  done    = 1'b1;
                  succ    = 1'b1;
               end else begin
                  dir_in     = ~pos_neg && (pos_ff != '0);
                  start      = 1'b1;
                  start_half = swmc_pkg::half_for(csr.speed, csr.extra_delay);
               end
            end
            swmc_pkg::MD_IDLE: begin
            end
         endcase
      end

      if (start) begin
         half_in = start_half;
      end
      pulse_mid = start ? 1'b1 : pulse_ff;
      timer_mid = start ? start_half : timer_ff;
      timer_dec = timer_mid - swmc_pkg::HALF_W'(1);
      pulse_in  = pulse_mid;
      timer_in  = timer_mid;

      if (pulse_mid || timer_mid != '0) begin
         step_out = pulse_mid;
         timer_in = timer_dec;
         if (timer_dec == '0) begin
            if (pulse_mid) begin
               pulse_in = 1'b0;
               timer_in = half_in;
            end else if (dir_in) begin
               pos_in = pos_in - swmc_pkg::POS_W'(swmc_pkg::step_size(res_in));
            end else begin
               pos_in = pos_in + swmc_pkg::POS_W'(swmc_pkg::step_size(res_in));
            end
         end
      end

      rsp_valid_in = take | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         res_ff       <= swmc_pkg::RES_FINEST;
         dir_ff       <= 1'b0;
         pulse_ff     <= 1'b0;
         timer_ff     <= '0;
         half_ff      <= swmc_pkg::HALF_W'(1);
         mode_ff      <= swmc_pkg::MD_IDLE;
         backoff_ff   <= '0;
         stop_ff      <= 1'b0;
         enable_ff    <= 1'b0;
         sdir_ff      <= 1'b0;
         sres_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            pos_ff     <= pos_in;
            res_ff     <= res_in;
            dir_ff     <= dir_in;
            pulse_ff   <= pulse_in;
            timer_ff   <= timer_in;
            half_ff    <= half_in;
            mode_ff    <= mode_in;
            backoff_ff <= backoff_in;
            stop_ff    <= stop_in;
            enable_ff  <= enable_in;
            sdir_ff    <= sdir_in;
            sres_ff    <= sres_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         step_out_ff   <= step_out;
         dir_out_ff    <= dir_in;
         res_out_ff    <= res_in;
         enable_out_ff <= enable_in;
         pos_out_ff    <= 32'(signed'(pos_in));
         busy_out_ff   <= (mode_in != swmc_pkg::MD_IDLE);
         done_out_ff   <= done;
         succ_out_ff   <= done & succ;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_pulse     = step_out_ff;
   assign rsp_dir_level      = dir_out_ff;
   assign rsp_microstep_pins = res_out_ff;
   assign rsp_enable_n       = enable_out_ff;
   assign rsp_position       = pos_out_ff;
   assign rsp_busy_res       = busy_out_ff;
   assign rsp_done_res       = done_out_ff;
   assign rsp_success        = succ_out_ff;

endmodule

/* hdl/stepper_window_motion_controller.sv */
// Channel   Direction  Handshake             Contents
// req_      in         req_valid/req_stall   one tick: operation, limit levels, resolution
// rsp_      out        rsp_valid/rsp_stall   one tick result: step, direction, position, status
// csr       in/out     psel/penable/pready   configuration registers at 4*index
//
// One request is accepted per clock while req_stall is low; each request yields exactly one response.
// A request passes through a two-entry queue and the execution stage, so its
// response is presented from the registered outputs of the execution stage.
// Reset is synchronous and restores idle mode, position zero and finest resolution.
// A stalled response holds in the output register while the queue keeps accepting until it is full.
module stepper_window_motion_controller (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [2:0]                   req_operation,
   input  logic                         req_limit_home,
   input  logic                         req_limit_open,
   input  logic                         req_limit_closed,
   input  logic [1:0]                   req_resolution_code,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_step_pulse,
   output logic                         rsp_dir_level,
   output logic [1:0]                   rsp_microstep_pins,
   output logic                         rsp_enable_n,
   output logic signed [31:0]           rsp_position,
   output logic                         rsp_busy_res,
   output logic                         rsp_done_res,
   output logic                         rsp_success,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [swmc_pkg::ADDR_W-1:0]  paddr,
   input  logic [swmc_pkg::DATA_W-1:0]  pwdata,
   output logic [swmc_pkg::DATA_W-1:0]  prdata,
   output logic                         pready
);

   swmc_pkg::csr_type csr;
   swmc_pkg::cmd_type deq_cmd;
   logic              deq_valid;
   logic              deq_ready;

   swmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   swmc_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_limit_home      (req_limit_home),
      .req_limit_open      (req_limit_open),
      .req_limit_closed    (req_limit_closed),
      .req_resolution_code (req_resolution_code),
      .deq_valid           (deq_valid),
      .deq_ready           (deq_ready),
      .deq_cmd             (deq_cmd)
   );

   swmc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr                (csr),
      .deq_valid          (deq_valid),
      .deq_ready          (deq_ready),
      .deq_cmd            (deq_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_step_pulse     (rsp_step_pulse),
      .rsp_dir_level      (rsp_dir_level),
      .rsp_microstep_pins (rsp_microstep_pins),
      .rsp_enable_n       (rsp_enable_n),
      .rsp_position       (rsp_position),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_success        (rsp_success)
   );

endmodule

/* sim/stepper_window_motion_controller_checker.sv */
module stepper_window_motion_controller_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [2:0]                  req_operation,
   input  logic                        req_limit_home,
   input  logic                        req_limit_open,
   input  logic                        req_limit_closed,
   input  logic [1:0]                  req_resolution_code,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic                        rsp_step_pulse,
   input  logic                        rsp_dir_level,
   input  logic [1:0]                  rsp_microstep_pins,
   input  logic                        rsp_enable_n,
   input  logic signed [31:0]          rsp_position,
   input  logic                        rsp_busy_res,
   input  logic                        rsp_done_res,
   input  logic                        rsp_success,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [swmc_pkg::ADDR_W-1:0] paddr,
   input  logic [swmc_pkg::DATA_W-1:0] pwdata,
   input  logic                        pready,
   output int                          fail_count,
   output int                          pending
);

   typedef struct {
      logic        pulse;
      logic        dir;
      logic [1:0]  pins;
      logic        en_n;
      logic [31:0] pos;
      logic        busy;
      logic        done;
      logic        ok;
   } tick_out_type;

   swmc_pkg::csr_type  regs_q;
   logic [31:0]        pos_q;
   logic [1:0]         res_q;
   logic               dir_q;
   logic               pulse_q;
   int                 timer_q;
   int                 latch_q;
   swmc_pkg::mode_type mode_q;
   int                 backoff_q;
   logic               stop_q;
   logic               dis_q;
   logic               saved_dir_q;
   logic [1:0]         saved_res_q;

   tick_out_type predicted_ticks[$];
   int           mismatches = 0;
   int           outstanding = 0;

   assign fail_count = mismatches;
   assign pending    = outstanding;

   function automatic int half_ticks(input logic [7:0] spd);
      int h;
      h = int'(spd) * swmc_pkg::TICKS_PER_SPEED_UNIT
          + (regs_q.extra_delay ? swmc_pkg::QUIET_EXTRA_TICKS : 0);
      return (h == 0) ? 1 : h;
   endfunction

   function automatic int ustep(input logic [1:0] code);
      int s;
      s = swmc_pkg::FINEST_MICROSTEPS / (8 << code);
      return (s == 0) ? 1 : s;
   endfunction

   function automatic void begin_step(input int h);
      latch_q = h;
      pulse_q = 1'b1;
      timer_q = h;
   endfunction

   task automatic advance_motion(input swmc_pkg::op_type op, input logic lh, input logic lo,
                                 input logic lc, input logic [1:0] rc);
      tick_out_type r;
      logic         done;
      logic         ok;
      logic         lvl;
      logic         again;
      logic         lim;
      logic [31:0]  tgt;
      longint       p;
      longint       d;
      longint       rem;
      done = 1'b0;
      ok   = 1'b0;
      lvl  = 1'b0;
      case (op)
         swmc_pkg::OP_STOP:    stop_q = 1'b1;
         swmc_pkg::OP_ENABLE:  dis_q = 1'b0;
         swmc_pkg::OP_DISABLE: dis_q = 1'b1;
         default: if (mode_q == swmc_pkg::MD_IDLE) begin
            case (op)
               swmc_pkg::OP_OPEN: begin
                  dir_q  = regs_q.open_direction;
                  stop_q = 1'b0;
                  mode_q = swmc_pkg::MD_OPEN;
               end
               swmc_pkg::OP_CLOSE: begin
                  dir_q  = regs_q.close_direction;
                  stop_q = 1'b0;
                  mode_q = swmc_pkg::MD_CLOSE;
               end
               swmc_pkg::OP_HOME: begin
                  saved_dir_q = dir_q;
                  saved_res_q = res_q;
                  dir_q       = regs_q.home_direction;
                  res_q       = swmc_pkg::RES_FINEST;
                  mode_q      = swmc_pkg::MD_SEEK;
               end
               swmc_pkg::OP_SET_RES: if (rc < res_q) begin
                  saved_dir_q = dir_q;
                  saved_res_q = rc;
                  mode_q      = swmc_pkg::MD_ALIGN;
               end else begin
                  res_q = rc;
                  done  = 1'b1;
                  ok    = 1'b1;
               end
               default: ;
            endcase
         end
      endcase

      // End conditions are only looked at on the tick where a new step would begin.
      if (mode_q != swmc_pkg::MD_IDLE && !pulse_q && timer_q == 0) begin
         again = 1'b1;
         while (again) begin
            again = 1'b0;
            case (mode_q)
               swmc_pkg::MD_OPEN, swmc_pkg::MD_CLOSE: begin
                  lim = (mode_q == swmc_pkg::MD_OPEN) ? lo : lc;
                  tgt = (mode_q == swmc_pkg::MD_OPEN) ? regs_q.open_target
                                                      : regs_q.closed_target;
                  if (stop_q) begin
                     mode_q = swmc_pkg::MD_IDLE;
                     done   = 1'b1;
                     ok     = 1'b0;
                  end else if (lim || pos_q == tgt) begin
                     mode_q = swmc_pkg::MD_IDLE;
                     done   = 1'b1;
                     ok     = 1'b1;
                  end else begin
                     begin_step(half_ticks(regs_q.speed));
                  end
               end
               swmc_pkg::MD_SEEK: if (lh) begin
                  mode_q = swmc_pkg::MD_RELEASE;
                  dir_q  = !regs_q.home_direction;
                  again  = 1'b1;
               end else begin
                  begin_step(half_ticks(swmc_pkg::SEEK_SPEED));
               end
               swmc_pkg::MD_RELEASE: if (!lh) begin
                  mode_q    = swmc_pkg::MD_BACKOFF;
                  backoff_q = swmc_pkg::BACKOFF_STEPS;
                  again     = 1'b1;
               end else begin
                  begin_step(half_ticks(swmc_pkg::BACK_SPEED));
               end
               swmc_pkg::MD_BACKOFF: if (backoff_q == 0) begin
                  mode_q = swmc_pkg::MD_SLOW;
                  dir_q  = regs_q.home_direction;
                  again  = 1'b1;
               end else begin
                  backoff_q--;
                  begin_step(half_ticks(swmc_pkg::BACK_SPEED));
               end
               swmc_pkg::MD_SLOW: if (lh) begin
                  pos_q  = '0;
                  dir_q  = saved_dir_q;
                  res_q  = saved_res_q;
                  mode_q = swmc_pkg::MD_IDLE;
                  done   = 1'b1;
                  ok     = 1'b1;
               end else begin
                  begin_step(half_ticks(swmc_pkg::SLOW_SPEED));
               end
               swmc_pkg::MD_ALIGN: begin
                  p   = longint'($signed(pos_q));
                  d   = longint'(ustep(saved_res_q));
                  rem = p % d;
                  if (rem < 0) begin
                     rem = -rem;
                  end
                  if (rem < longint'(ustep(res_q))) begin
                     dir_q  = saved_dir_q;
                     res_q  = saved_res_q;
                     mode_q = swmc_pkg::MD_IDLE;
                     done   = 1'b1;
                     ok     = 1'b1;
                  end else begin
                     dir_q = (p > 0);
                     begin_step(half_ticks(regs_q.speed));
                  end
               end
               default: ;
            endcase
         end
      end

      if (pulse_q || timer_q != 0) begin
         lvl = pulse_q;
         timer_q--;
         if (timer_q == 0) begin
            if (pulse_q) begin
               pulse_q = 1'b0;
               timer_q = latch_q;
            end else if (dir_q) begin
               pos_q = pos_q - 32'(ustep(res_q));
            end else begin
               pos_q = pos_q + 32'(ustep(res_q));
            end
         end
      end

      r.pulse = lvl;
      r.dir   = dir_q;
      r.pins  = res_q;
      r.en_n  = dis_q;
      r.pos   = pos_q;
      r.busy  = (mode_q != swmc_pkg::MD_IDLE);
      r.done  = done;
      r.ok    = done & ok;
      predicted_ticks.push_back(r);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      tick_out_type want;
      if (reset) begin
         regs_q      = '{speed: 8'd1, extra_delay: 1'b0, home_direction: 1'b0,
                         open_direction: 1'b0, close_direction: 1'b1,
                         open_target: '0, closed_target: '0};
         pos_q       = '0;
         res_q       = swmc_pkg::RES_FINEST;
         dir_q       = 1'b0;
         pulse_q     = 1'b0;
         timer_q     = 0;
         latch_q     = 1;
         mode_q      = swmc_pkg::MD_IDLE;
         backoff_q   = 0;
         stop_q      = 1'b0;
         dis_q       = 1'b0;
         saved_dir_q = 1'b0;
         saved_res_q = '0;
         predicted_ticks.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (swmc_pkg::reg_type'(paddr[swmc_pkg::ADDR_W-1:2]))
               swmc_pkg::REG_SPEED:           regs_q.speed           = pwdata[7:0];
               swmc_pkg::REG_EXTRA_DELAY:     regs_q.extra_delay     = pwdata[0];
               swmc_pkg::REG_HOME_DIRECTION:  regs_q.home_direction  = pwdata[0];
               swmc_pkg::REG_OPEN_DIRECTION:  regs_q.open_direction  = pwdata[0];
               swmc_pkg::REG_CLOSE_DIRECTION: regs_q.close_direction = pwdata[0];
               swmc_pkg::REG_OPEN_TARGET:     regs_q.open_target     = pwdata[31:0];
               swmc_pkg::REG_CLOSED_TARGET:   regs_q.closed_target   = pwdata[31:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_motion(swmc_pkg::op_type'(req_operation), req_limit_home, req_limit_open,
                           req_limit_closed, req_resolution_code);
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_ticks.size() == 0) begin
               $error("response arrived with no request outstanding");
               mismatches++;
            end else begin
               want = predicted_ticks.pop_front();
               check_field("step_pulse", 32'(want.pulse), 32'(rsp_step_pulse));
               check_field("dir_level", 32'(want.dir), 32'(rsp_dir_level));
               check_field("microstep_pins", 32'(want.pins), 32'(rsp_microstep_pins));
               check_field("enable_n", 32'(want.en_n), 32'(rsp_enable_n));
               check_field("position", want.pos, rsp_position);
               check_field("busy_res", 32'(want.busy), 32'(rsp_busy_res));
               check_field("done_res", 32'(want.done), 32'(rsp_done_res));
               check_field("success", 32'(want.ok), 32'(rsp_success));
            end
         end
      end
      outstanding <= predicted_ticks.size();
   end

endmodule

/* sim/stepper_window_motion_controller_test.sv */
module stepper_window_motion_controller_test;

   localparam int RUN_LIMIT = 1000000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [2:0]                   req_operation = swmc_pkg::OP_NONE;
   logic                         req_limit_home = 1'b0;
   logic                         req_limit_open = 1'b0;
   logic                         req_limit_closed = 1'b0;
   logic [1:0]                   req_resolution_code = 2'd0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_step_pulse;
   logic                         rsp_dir_level;
   logic [1:0]                   rsp_microstep_pins;
   logic                         rsp_enable_n;
   logic signed [31:0]           rsp_position;
   logic                         rsp_busy_res;
   logic                         rsp_done_res;
   logic                         rsp_success;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [swmc_pkg::ADDR_W-1:0]  paddr = '0;
   logic [swmc_pkg::DATA_W-1:0]  pwdata = '0;
   logic [swmc_pkg::DATA_W-1:0]  prdata;
   logic                         pready;
   int                           fail_count;
   int                           pending;

   int idle_pct = 0;
   int stall_pct = 0;
   int sent_items = 0;
   int cycle_count = 0;

   stepper_window_motion_controller i_dut (.*);

   stepper_window_motion_controller_checker i_checker (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("[stepper_window_motion_controller] ERROR");
         $finish;
      end
   end

   function automatic logic chance(input int n);
      return $urandom_range(0, n - 1) == 0;
   endfunction

   function automatic swmc_pkg::op_type motion_noise();
      case ($urandom_range(0, 59))
         0, 1, 2: return swmc_pkg::OP_STOP;
         3:       return swmc_pkg::OP_ENABLE;
         4:       return swmc_pkg::OP_DISABLE;
         5:       return swmc_pkg::OP_OPEN;
         6:       return swmc_pkg::OP_CLOSE;
         7:       return swmc_pkg::OP_SET_RES;
         default: return swmc_pkg::OP_NONE;
      endcase
   endfunction

   task automatic send_tick(input swmc_pkg::op_type op, input logic lh, input logic lo,
                            input logic lc, input logic [1:0] rc);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_limit_home      <= lh;
      req_limit_open      <= lo;
      req_limit_closed    <= lc;
      req_resolution_code <= rc;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent_items++;
   endtask

   initial begin
      swmc_pkg::csr_type settings;
      swmc_pkg::op_type  op;
      int                goal;
      int                n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               settings = '{speed: 8'd0, extra_delay: 1'b0, home_direction: 1'b0,
                            open_direction: 1'b0, close_direction: 1'b1,
                            open_target: 32'sd48, closed_target: -32'sd40};
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               settings = '{speed: 8'd255, extra_delay: 1'b1, home_direction: 1'b1,
                            open_direction: 1'b1, close_direction: 1'b0,
                            open_target: 32'h7FFF_FFFF, closed_target: 32'h8000_0000};
               idle_pct  = 70;
               stall_pct = 0;
            end
            2: begin
               settings.speed           = 8'($urandom_range(0, 6));
               settings.extra_delay     = 1'b0;
               settings.home_direction  = 1'($urandom_range(0, 1));
               settings.open_direction  = 1'($urandom_range(0, 1));
               settings.close_direction = 1'($urandom_range(0, 1));
               settings.open_target     = 32'(int'($urandom_range(0, 128)) - 64);
               settings.closed_target   = 32'(int'($urandom_range(0, 128)) - 64);
               idle_pct  = 0;
               stall_pct = 70;
            end
            default: begin
               settings.speed           = 8'd1;
               settings.extra_delay     = 1'b0;
               settings.home_direction  = 1'($urandom_range(0, 1));
               settings.open_direction  = 1'b0;
               settings.close_direction = 1'b1;
               settings.open_target     = 32'(int'($urandom_range(0, 192)) - 96);
               settings.closed_target   = 32'(int'($urandom_range(0, 192)) - 96);
               idle_pct  = 9;
               stall_pct = 9;
            end
         endcase

         for (int r = swmc_pkg::REG_SPEED; r <= swmc_pkg::REG_CLOSED_TARGET; r++) begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {swmc_pkg::reg_type'(r), 2'b00};
            case (swmc_pkg::reg_type'(r))
               swmc_pkg::REG_SPEED:           pwdata <= 32'(settings.speed);
               swmc_pkg::REG_EXTRA_DELAY:     pwdata <= 32'(settings.extra_delay);
               swmc_pkg::REG_HOME_DIRECTION:  pwdata <= 32'(settings.home_direction);
               swmc_pkg::REG_OPEN_DIRECTION:  pwdata <= 32'(settings.open_direction);
               swmc_pkg::REG_CLOSE_DIRECTION: pwdata <= 32'(settings.close_direction);
               swmc_pkg::REG_OPEN_TARGET:     pwdata <= settings.open_target;
               default:                       pwdata <= settings.closed_target;
            endcase
            @(posedge clock);
            penable <= 1'b1;
            @(posedge clock);
            while (!pready) begin
               @(posedge clock);
            end
         end
         psel    <= 1'b0;
         penable <= 1'b0;
         pwrite  <= 1'b0;

         if (ph == 0) begin
            send_tick(swmc_pkg::OP_NONE, 1'b1, 1'b1, 1'b1, 2'd3);
            send_tick(swmc_pkg::OP_DISABLE, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_ENABLE, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_SET_RES, 1'b0, 1'b0, 1'b0, 2'd3);
            send_tick(swmc_pkg::OP_SET_RES, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_SET_RES, 1'b0, 1'b0, 1'b0, 2'd2);
            send_tick(swmc_pkg::OP_OPEN, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_HOME, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_CLOSE, 1'b0, 1'b0, 1'b0, 2'd0);
            repeat (3) send_tick(swmc_pkg::OP_NONE, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_STOP, 1'b0, 1'b0, 1'b0, 2'd0);
            repeat (2) send_tick(swmc_pkg::OP_NONE, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_CLOSE, 1'b0, 1'b0, 1'b1, 2'd0);
            send_tick(swmc_pkg::OP_OPEN, 1'b0, 1'b1, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_CLOSE, 1'b0, 1'b0, 1'b0, 2'd0);
            repeat (3) send_tick(swmc_pkg::OP_NONE, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_STOP, 1'b0, 1'b0, 1'b0, 2'd0);
            repeat (2) send_tick(swmc_pkg::OP_NONE, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_SET_RES, 1'b0, 1'b0, 1'b0, 2'd0);
            repeat (3) send_tick(swmc_pkg::OP_NONE, 1'b0, 1'b0, 1'b0, 2'd0);
         end

         goal = sent_items + 280;
         while (sent_items < goal) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  send_tick(chance(2) ? swmc_pkg::OP_OPEN : swmc_pkg::OP_CLOSE, chance(8),
                            chance(12), chance(12), 2'($urandom_range(0, 3)));
                  n = $urandom_range(0, 150);
                  repeat (n) begin
                     send_tick(motion_noise(), chance(8), chance(12), chance(12),
                               2'($urandom_range(0, 3)));
                  end
                  if (!chance(4)) begin
                     send_tick(swmc_pkg::OP_STOP, chance(8), chance(12), chance(12), 2'd0);
                  end
                  n = $urandom_range(0, 10);
                  repeat (n) begin
                     send_tick(swmc_pkg::OP_NONE, chance(8), chance(12), chance(12), 2'd0);
                  end
               end
               5, 6: begin
                  send_tick(swmc_pkg::OP_SET_RES, chance(8), chance(12), chance(12),
                            2'($urandom_range(0, 3)));
                  n = $urandom_range(0, 40);
                  repeat (n) begin
                     send_tick(swmc_pkg::OP_NONE, chance(8), chance(12), chance(12), 2'd0);
                  end
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0:       op = swmc_pkg::OP_STOP;
                     1:       op = swmc_pkg::OP_ENABLE;
                     2:       op = swmc_pkg::OP_DISABLE;
                     default: op = swmc_pkg::OP_NONE;
                  endcase
                  send_tick(op, chance(2), chance(2), chance(2), 2'($urandom_range(0, 3)));
               end
            endcase
         end

         // A homing run: stop anything running, then seek, release and begin the back-off.
         if (ph == 3) begin
            send_tick(swmc_pkg::OP_STOP, 1'b0, 1'b0, 1'b0, 2'd0);
            repeat (40) send_tick(swmc_pkg::OP_NONE, 1'b0, 1'b0, 1'b0, 2'd0);
            send_tick(swmc_pkg::OP_HOME, 1'b0, 1'b0, 1'b0, 2'd0);
            n = $urandom_range(0, 30);
            repeat (n) send_tick(swmc_pkg::OP_NONE, 1'b0, chance(2), chance(2), 2'd0);
            n = $urandom_range(5, 20);
            repeat (n) send_tick(swmc_pkg::OP_NONE, 1'b1, chance(2), chance(2), 2'd0);
            repeat (200) begin
               send_tick(chance(40) ? swmc_pkg::OP_HOME : motion_noise(), 1'b0, chance(2),
                         chance(2), 2'($urandom_range(0, 3)));
            end
         end

         req_valid <= 1'b0;
         @(posedge clock);
         while (pending != 0) begin
            @(posedge clock);
         end
      end

      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("[stepper_window_motion_controller] OK");
      end else begin
         $display("[stepper_window_motion_controller] ERROR");
      end
      $finish;
   end

endmodule
